/* sv/lhb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhb_pkg
// Shared types and constants of the latency histogram binner.
// ----------------------------------------------------------------------------
package lhb_pkg;

  // table geometry
  localparam int BUCKETS  = 64;
  localparam int ADDR_W   = $clog2(BUCKETS);
  localparam int IDX_W    = $clog2(BUCKETS + 1);
  localparam int BOUND_W  = 48;
  localparam int COUNT_W  = 64;
  localparam int AMOUNT_W = 32;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_RECORD = 2'd1,
    CMD_READ   = 2'd2
  } cmd_t;

  // status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_UNSORTED  = 2'd1,
    ST_DUPLICATE = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  // memory access controls from the sequencer to the storage
  typedef struct packed {
    logic              bound_re;
    logic [ADDR_W-1:0] bound_raddr;
    logic              bound_we;
    logic [ADDR_W-1:0] bound_waddr;
    logic              count_re;
    logic [ADDR_W-1:0] count_raddr;
    logic              count_we;
    logic [ADDR_W-1:0] count_waddr;
  } mem_req_t;

endpackage

/* sv/lhb_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhb_req_if
// Request channel: one beat carries a load, record or read command.
// ----------------------------------------------------------------------------
interface lhb_req_if;
  logic                         valid;
  logic                         ready;
  logic [lhb_pkg::CMD_W-1:0]    cmd;
  logic [lhb_pkg::IDX_W-1:0]    index;
  logic [lhb_pkg::BOUND_W-1:0]  value;
  logic [lhb_pkg::AMOUNT_W-1:0] amount;

  modport source (output valid, cmd, index, value, amount, input ready);
  modport sink   (input valid, cmd, index, value, amount, output ready);
endinterface

/* sv/lhb_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhb_rsp_if
// Result channel: one beat per request.
// ----------------------------------------------------------------------------
interface lhb_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [lhb_pkg::STATUS_W-1:0] status;
  logic [lhb_pkg::IDX_W-1:0]    bucket_hit;
  logic [lhb_pkg::BOUND_W-1:0]  bound_out;
  logic [lhb_pkg::COUNT_W-1:0]  count_out;

  modport source (output valid, status, bucket_hit, bound_out, count_out, input ready);
  modport sink   (input valid, status, bucket_hit, bound_out, count_out, output ready);
endinterface

/* sv/lhb_cfg_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhb_cfg_if
// Configuration write channel for the bucket_count register.
// ----------------------------------------------------------------------------
interface lhb_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [lhb_pkg::IDX_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* sv/latency_histogram_binner.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// latency_histogram_binner
// Latency histogram over a table of ascending bucket bounds with 64-bit
// wrapping counters and an overflow counter.
// ----------------------------------------------------------------------------
// One request is in flight at a time; the next is taken once the current one
// has moved to the output register, even while that result waits. A load
// checks the predecessor bound first (not at index zero or out of range),
// a read fetches bound and count (not for the overflow count or out of
// range). A record runs a binary search that reads the bound memory once
// per probe, one probe per cycle, up to 7 probes for a full table, then
// reads and writes back the chosen counter, or updates the overflow counter.
// Counters are cleared at reset through per-entry valid bits; there is no
// clearing pass. Bounds must be loaded before they are searched or read.
// bucket_count writes are taken at any time and should only be made while
// the block is idle.
// ----------------------------------------------------------------------------
module latency_histogram_binner (
  input  logic       clk,
  input  logic       rst,
  lhb_cfg_if.sink    cfg,
  lhb_req_if.sink    request,
  lhb_rsp_if.source  result
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_LCHK  = 7'b0000010,
    S_SRCH  = 7'b0000100,
    S_FETCH = 7'b0001000,
    S_UPD   = 7'b0010000,
    S_RDAT  = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

  state_t state, state_next;

  // config and overflow
  logic [lhb_pkg::IDX_W-1:0]    bucket_count;
  logic [lhb_pkg::COUNT_W-1:0]  overflow_count, overflow_count_next;

  // current operation
  logic [lhb_pkg::IDX_W-1:0]    op_idx, op_idx_next;
  logic [lhb_pkg::BOUND_W-1:0]  op_val, op_val_next;
  logic [lhb_pkg::AMOUNT_W-1:0] op_amt, op_amt_next;

  // search window
  logic [lhb_pkg::IDX_W-1:0]    first, first_next;
  logic [lhb_pkg::IDX_W-1:0]    len, len_next;
  logic [lhb_pkg::ADDR_W-1:0]   probe, probe_next;

  // pending result
  logic [lhb_pkg::STATUS_W-1:0] res_status, res_status_next;
  logic [lhb_pkg::IDX_W-1:0]    res_hit, res_hit_next;
  logic [lhb_pkg::BOUND_W-1:0]  res_bound, res_bound_next;
  logic [lhb_pkg::COUNT_W-1:0]  res_count, res_count_next;

  // output register
  logic                         o_valid;
  logic [lhb_pkg::STATUS_W-1:0] o_status;
  logic [lhb_pkg::IDX_W-1:0]    o_hit;
  logic [lhb_pkg::BOUND_W-1:0]  o_bound;
  logic [lhb_pkg::COUNT_W-1:0]  o_count;
  logic                         o_load;

  // memory side
  lhb_pkg::mem_req_t            mreq;
  logic [lhb_pkg::BOUND_W-1:0]  bound_wdata, bound_rdata;
  logic [lhb_pkg::COUNT_W-1:0]  count_wdata, count_rdata;

  // helpers
  logic                         acc;
  logic [lhb_pkg::IDX_W-1:0]    n_search;
  logic [lhb_pkg::IDX_W-1:0]    half;
  logic [lhb_pkg::IDX_W-1:0]    f_n, l_n, nxt_probe;
  logic                         ovf;
  logic [lhb_pkg::COUNT_W-1:0]  ovf_sum, cnt_sum;

  lhb_mem u_mem (
    .clk         (clk),
    .rst         (rst),
    .req         (mreq),
    .bound_wdata (bound_wdata),
    .count_wdata (count_wdata),
    .bound_rdata (bound_rdata),
    .count_rdata (count_rdata)
  );

  assign request.ready = (state == S_IDLE);
  assign acc           = request.valid && request.ready;
  assign cfg.ready     = 1'b1;

  // search length saturates at the table size
  assign n_search = (bucket_count > lhb_pkg::IDX_W'(lhb_pkg::BUCKETS))
                  ? lhb_pkg::IDX_W'(lhb_pkg::BUCKETS) : bucket_count;

  // one search step on the probed bound
  assign half      = len >> 1;
  assign f_n       = (bound_rdata < op_val)
                   ? (lhb_pkg::IDX_W'(probe) + lhb_pkg::IDX_W'(1)) : first;
  assign l_n       = (bound_rdata < op_val) ? (len - half - lhb_pkg::IDX_W'(1)) : half;
  assign nxt_probe = f_n + (l_n >> 1);

  assign ovf     = (first >= lhb_pkg::IDX_W'(lhb_pkg::BUCKETS)) || (first >= bucket_count);
  assign ovf_sum = overflow_count + lhb_pkg::COUNT_W'(op_amt);
  assign cnt_sum = count_rdata + lhb_pkg::COUNT_W'(op_amt);

  assign o_load = (state == S_FIN) && (!o_valid || result.ready);

  // sequencer
  always_comb begin
    state_next          = state;
    overflow_count_next = overflow_count;
    op_idx_next         = op_idx;
    op_val_next         = op_val;
    op_amt_next         = op_amt;
    first_next          = first;
    len_next            = len;
    probe_next          = probe;
    res_status_next     = res_status;
    res_hit_next        = res_hit;
    res_bound_next      = res_bound;
    res_count_next      = res_count;
    mreq                = '0;
    bound_wdata         = op_val;
    count_wdata         = cnt_sum;

    case (state)
      S_IDLE: begin
        if (acc) begin
          op_idx_next     = request.index;
          op_val_next     = request.value;
          op_amt_next     = request.amount;
          res_status_next = lhb_pkg::ST_OK;
          res_hit_next    = '0;
          res_bound_next  = '0;
          res_count_next  = '0;
          state_next      = S_FIN;
          case (request.cmd)
            lhb_pkg::CMD_LOAD: begin
              if (request.index >= lhb_pkg::IDX_W'(lhb_pkg::BUCKETS)) begin
                res_status_next = lhb_pkg::ST_RANGE;
              end else if (request.index == '0) begin
                // no predecessor at index zero
                mreq.bound_we    = 1'b1;
                mreq.bound_waddr = '0;
                bound_wdata      = request.value;
              end else begin
                mreq.bound_re    = 1'b1;
                mreq.bound_raddr = lhb_pkg::ADDR_W'(request.index - lhb_pkg::IDX_W'(1));
                state_next       = S_LCHK;
              end
            end
            lhb_pkg::CMD_RECORD: begin
              first_next = '0;
              len_next   = n_search;
              if (n_search != '0) begin
                mreq.bound_re    = 1'b1;
                mreq.bound_raddr = lhb_pkg::ADDR_W'(n_search >> 1);
                probe_next       = lhb_pkg::ADDR_W'(n_search >> 1);
                state_next       = S_SRCH;
              end else begin
                state_next = S_FETCH;
              end
            end
            lhb_pkg::CMD_READ: begin
              if (request.index < lhb_pkg::IDX_W'(lhb_pkg::BUCKETS)) begin
                mreq.bound_re    = 1'b1;
                mreq.bound_raddr = lhb_pkg::ADDR_W'(request.index);
                mreq.count_re    = 1'b1;
                mreq.count_raddr = lhb_pkg::ADDR_W'(request.index);
                state_next       = S_RDAT;
              end else if (request.index == lhb_pkg::IDX_W'(lhb_pkg::BUCKETS)) begin
                res_count_next = overflow_count;
              end else begin
                res_status_next = lhb_pkg::ST_RANGE;
              end
            end
            default: begin
              // unused command: empty result
            end
          endcase
        end
      end

      // load: compare against the predecessor bound
      S_LCHK: begin
        if (op_val < bound_rdata) begin
          res_status_next = lhb_pkg::ST_UNSORTED;
        end else if (op_val == bound_rdata) begin
          res_status_next = lhb_pkg::ST_DUPLICATE;
        end else begin
          mreq.bound_we    = 1'b1;
          mreq.bound_waddr = lhb_pkg::ADDR_W'(op_idx);
        end
        state_next = S_FIN;
      end

      // record: one probe per cycle, next read issued from the new window
      S_SRCH: begin
        first_next = f_n;
        len_next   = l_n;
        if (l_n != '0) begin
          mreq.bound_re    = 1'b1;
          mreq.bound_raddr = lhb_pkg::ADDR_W'(nxt_probe);
          probe_next       = lhb_pkg::ADDR_W'(nxt_probe);
        end else begin
          state_next = S_FETCH;
        end
      end

      // record: overflow updates the register, else fetch the bucket
      S_FETCH: begin
        if (ovf) begin
          overflow_count_next = ovf_sum;
          res_hit_next        = lhb_pkg::IDX_W'(lhb_pkg::BUCKETS);
          res_count_next      = ovf_sum;
          state_next          = S_FIN;
        end else begin
          mreq.bound_re    = 1'b1;
          mreq.bound_raddr = lhb_pkg::ADDR_W'(first);
          mreq.count_re    = 1'b1;
          mreq.count_raddr = lhb_pkg::ADDR_W'(first);
          state_next       = S_UPD;
        end
      end

      // record: add and write back the counter
      S_UPD: begin
        mreq.count_we    = 1'b1;
        mreq.count_waddr = lhb_pkg::ADDR_W'(first);
        res_hit_next     = first;
        res_bound_next   = bound_rdata;
        res_count_next   = cnt_sum;
        state_next       = S_FIN;
      end

      S_RDAT: begin
        res_bound_next = bound_rdata;
        res_count_next = count_rdata;
        state_next     = S_FIN;
      end

      // hand the result to the output register
      S_FIN: begin
        if (o_load) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      bucket_count   <= '0;
      overflow_count <= '0;
      o_valid        <= 1'b0;
    end else begin
      state          <= state_next;
      overflow_count <= overflow_count_next;
      if (cfg.valid && cfg.ready) begin
        bucket_count <= cfg.data;
      end
      if (o_load) begin
        o_valid <= 1'b1;
      end else if (result.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_idx     <= op_idx_next;
    op_val     <= op_val_next;
    op_amt     <= op_amt_next;
    first      <= first_next;
    len        <= len_next;
    probe      <= probe_next;
    res_status <= res_status_next;
    res_hit    <= res_hit_next;
    res_bound  <= res_bound_next;
    res_count  <= res_count_next;
    if (o_load) begin
      o_status <= res_status;
      o_hit    <= res_hit;
      o_bound  <= res_bound;
      o_count  <= res_count;
    end
  end

  assign result.valid      = o_valid;
  assign result.status     = o_status;
  assign result.bucket_hit = o_hit;
  assign result.bound_out  = o_bound;
  assign result.count_out  = o_count;

endmodule

/* sv/lhb_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhb_mem
// Bound table and bucket counter memories, one read and one write port each,
// registered read data. Counter entries carry valid bits so reset reads zero.
// ----------------------------------------------------------------------------
module lhb_mem (
  input  logic                         clk,
  input  logic                         rst,
  input  lhb_pkg::mem_req_t            req,
  input  logic [lhb_pkg::BOUND_W-1:0]  bound_wdata,
  input  logic [lhb_pkg::COUNT_W-1:0]  count_wdata,
  output logic [lhb_pkg::BOUND_W-1:0]  bound_rdata,
  output logic [lhb_pkg::COUNT_W-1:0]  count_rdata
);

  logic [lhb_pkg::BOUND_W-1:0] bound_mem [lhb_pkg::BUCKETS];
  logic [lhb_pkg::COUNT_W-1:0] count_mem [lhb_pkg::BUCKETS];
  logic [lhb_pkg::BUCKETS-1:0] count_vld;
  logic [lhb_pkg::BOUND_W-1:0] bound_q;
  logic [lhb_pkg::COUNT_W-1:0] count_q;
  logic                        count_vld_q;

  // bound table, no reset: user must not read before written (not enforced)
  always_ff @(posedge clk) begin
    if (req.bound_we) begin
      bound_mem[req.bound_waddr] <= bound_wdata;
    end
    if (req.bound_re) begin
      bound_q <= bound_mem[req.bound_raddr];
    end
  end

  // counter memory
  always_ff @(posedge clk) begin
    if (req.count_we) begin
      count_mem[req.count_waddr] <= count_wdata;
    end
    if (req.count_re) begin
      count_q     <= count_mem[req.count_raddr];
      count_vld_q <= count_vld[req.count_raddr];
    end
  end

  // per-entry valid bits, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      count_vld <= '0;
    end else if (req.count_we) begin
      count_vld[req.count_waddr] <= 1'b1;
    end
  end

  assign bound_rdata = bound_q;
  assign count_rdata = count_vld_q ? count_q : '0;

endmodule

/* sv/lhb_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhb_checker
// Port-level checks on the histogram binner, bound to the top level.
// ----------------------------------------------------------------------------
module lhb_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic [lhb_pkg::STATUS_W-1:0] rsp_status,
  input logic [lhb_pkg::IDX_W-1:0]    rsp_hit,
  input logic [lhb_pkg::BOUND_W-1:0]  rsp_bound,
  input logic [lhb_pkg::COUNT_W-1:0]  rsp_count
);

  // a stalled result beat stays up
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result beat dropped while stalled");

  // and keeps its payload
  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rsp_status) && $stable(rsp_hit)
                                && $stable(rsp_bound) && $stable(rsp_count))
    else $error("stalled result payload changed");

  // one request at a time: no back-to-back accepts
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while another is in flight");

  // nothing is delivered right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid after reset");

endmodule

bind latency_histogram_binner lhb_checker u_lhb_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (request.valid),
  .req_ready  (request.ready),
  .rsp_valid  (result.valid),
  .rsp_ready  (result.ready),
  .rsp_status (result.status),
  .rsp_hit    (result.bucket_hit),
  .rsp_bound  (result.bound_out),
  .rsp_count  (result.count_out)
);

/* tb/latency_histogram_binner_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// latency_histogram_binner_tb
// Self-checking bench for the latency histogram binner. A queue of
// load/record/read beats feeds a driver with random gaps. The result side
// stalls at random and once for a long stretch. A local model of the bound
// table and counters predicts every result, and each beat is checked in
// order. Random rounds rebuild an ascending bound ladder from index zero. They
// then set bucket_count between extremes and mix records, reads, stray loads
// and idle commands. Only bounds already loaded are ever searched or read.
// ----------------------------------------------------------------------------
module latency_histogram_binner_tb;

  localparam logic [lhb_pkg::CMD_W-1:0]   CMD_NOP        = 2'd3;
  localparam logic [lhb_pkg::BOUND_W-1:0] BOUND_MAX      = '1;
  localparam int                          IDX_TOP        = 127;
  localparam int                          IDLE_PCT       = 37;
  localparam int                          HOLD_CYCLES    = 400;
  localparam int                          WATCHDOG_LIMIT = 4000;
  localparam int                          ITEM_TARGET    = 1050;
  localparam int                          SHOW_LIMIT     = 10;

  typedef struct packed {
    logic [lhb_pkg::CMD_W-1:0]    cmd;
    logic [lhb_pkg::IDX_W-1:0]    index;
    logic [lhb_pkg::BOUND_W-1:0]  value;
    logic [lhb_pkg::AMOUNT_W-1:0] amount;
  } hist_cmd_t;

  typedef struct packed {
    logic [lhb_pkg::STATUS_W-1:0] status;
    logic [lhb_pkg::IDX_W-1:0]    bucket_hit;
    logic [lhb_pkg::BOUND_W-1:0]  bound;
    logic [lhb_pkg::COUNT_W-1:0]  count;
  } hist_rsp_t;

  logic clk = 1'b0;
  logic rst;

  lhb_cfg_if cfg ();
  lhb_req_if request ();
  lhb_rsp_if result ();

  latency_histogram_binner dut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .request (request),
    .result  (result)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // model of the histogram state
  logic [lhb_pkg::BOUND_W-1:0] bound_mem [lhb_pkg::BUCKETS] = '{default: '0};
  logic [lhb_pkg::COUNT_W-1:0] bin_tally [lhb_pkg::BUCKETS] = '{default: '0};
  bit                          bound_loaded [lhb_pkg::BUCKETS] = '{default: 1'b0};
  logic [lhb_pkg::COUNT_W-1:0] overflow_tally = '0;
  logic [lhb_pkg::IDX_W-1:0]   bins_in_use = '0;

  hist_cmd_t bin_cmd_q [$];
  hist_rsp_t bin_rsp_q [$];

  bit req_taken   = 1'b0;
  bit no_idle     = 1'b0;
  bit stall_go    = 1'b0;
  bit stall_done  = 1'b0;
  int hold_left   = 0;
  int quiet_count = 0;
  int fails       = 0;
  int n_items     = 0;

  // apply one command to the model and return the beat it must produce
  task automatic histogram_step(input hist_cmd_t rq, output hist_rsp_t rs);
    int span, lo, len, half, probe;
    rs = '0;
    case (rq.cmd)
      lhb_pkg::CMD_LOAD: begin
        if (rq.index >= lhb_pkg::BUCKETS) begin
          rs.status = lhb_pkg::ST_RANGE;
        end else if (rq.index != 0 && rq.value < bound_mem[rq.index - 1]) begin
          rs.status = lhb_pkg::ST_UNSORTED;
        end else if (rq.index != 0 && rq.value == bound_mem[rq.index - 1]) begin
          rs.status = lhb_pkg::ST_DUPLICATE;
        end else begin
          bound_mem[rq.index]    = rq.value;
          bound_loaded[rq.index] = 1'b1;
        end
      end
      lhb_pkg::CMD_RECORD: begin
        // lower-bound search, probe the middle, go right while probe < value
        span = (bins_in_use > lhb_pkg::BUCKETS) ? lhb_pkg::BUCKETS : int'(bins_in_use);
        lo   = 0;
        len  = span;
        while (len > 0) begin
          half  = len / 2;
          probe = lo + half;
          if (bound_mem[probe] < rq.value) begin
            lo  = probe + 1;
            len = len - half - 1;
          end else begin
            len = half;
          end
        end
        if (lo >= lhb_pkg::BUCKETS || lo >= int'(bins_in_use)) begin
          overflow_tally = overflow_tally + rq.amount;
          rs.bucket_hit  = lhb_pkg::IDX_W'(lhb_pkg::BUCKETS);
          rs.count       = overflow_tally;
        end else begin
          bin_tally[lo] = bin_tally[lo] + rq.amount;
          rs.bucket_hit = lhb_pkg::IDX_W'(lo);
          rs.bound      = bound_mem[lo];
          rs.count      = bin_tally[lo];
        end
      end
      lhb_pkg::CMD_READ: begin
        if (rq.index < lhb_pkg::BUCKETS) begin
          rs.bound = bound_mem[rq.index];
          rs.count = bin_tally[rq.index];
        end else if (rq.index == lhb_pkg::BUCKETS) begin
          rs.count = overflow_tally;
        end else begin
          rs.status = lhb_pkg::ST_RANGE;
        end
      end
      default: ;
    endcase
  endtask

  function automatic logic [lhb_pkg::BOUND_W-1:0] rand48();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[lhb_pkg::BOUND_W-1:0];
  endfunction

  task automatic add_item(input logic [lhb_pkg::CMD_W-1:0] c, input int i,
                          input logic [lhb_pkg::BOUND_W-1:0] v,
                          input logic [lhb_pkg::AMOUNT_W-1:0] a);
    hist_cmd_t item;
    item.cmd    = c;
    item.index  = lhb_pkg::IDX_W'(i);
    item.value  = v;
    item.amount = a;
    bin_cmd_q.insert(bin_cmd_q.size(), item);
    n_items++;
  endtask

  task automatic drain();
    while (bin_cmd_q.size() != 0 || bin_rsp_q.size() != 0) @(posedge clk);
  endtask

  // bucket_count is only written once the block has gone quiet
  task automatic set_bins(input int n);
    drain();
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.data  <= lhb_pkg::IDX_W'(n);
    do @(posedge clk); while (!(cfg.valid && cfg.ready));
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  // request driver: one beat per handshake, random gaps
  always @(negedge clk) begin
    bit        nv;
    hist_cmd_t cur;
    if (req_taken) void'(bin_cmd_q.pop_front());
    cur = '0;
    if (rst) begin
      nv = 1'b0;
    end else if (request.valid && !req_taken) begin
      nv = 1'b1;
    end else begin
      nv = bin_cmd_q.size() != 0 && (no_idle || $urandom_range(0, 99) >= IDLE_PCT);
    end
    if (bin_cmd_q.size() != 0) cur = bin_cmd_q[0];
    request.valid  <= nv;
    request.cmd    <= cur.cmd;
    request.index  <= cur.index;
    request.value  <= cur.value;
    request.amount <= cur.amount;
  end

  // result backpressure, with one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      result.ready <= 1'b0;
    end else if (stall_go && !stall_done) begin
      hold_left  = HOLD_CYCLES;
      stall_done = 1'b1;
      result.ready <= 1'b0;
    end else begin
      result.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // monitor: predict on request beats, check result beats
  always @(posedge clk) begin
    hist_cmd_t seen;
    hist_rsp_t want, got;
    req_taken = !rst && request.valid && request.ready;
    if (!rst && cfg.valid && cfg.ready) bins_in_use = cfg.data;
    if (req_taken) begin
      seen = {request.cmd, request.index, request.value, request.amount};
      histogram_step(seen, want);
      bin_rsp_q.insert(bin_rsp_q.size(), want);
    end
    if (!rst && result.valid && result.ready) begin
      got = {result.status, result.bucket_hit, result.bound_out, result.count_out};
      if (bin_rsp_q.size() == 0) begin
        fails++;
        if (fails <= SHOW_LIMIT)
          $display("%0t: result beat with nothing expected: st=%0d hit=%0d bound=%h count=%h",
                   $realtime, got.status, got.bucket_hit, got.bound, got.count);
      end else begin
        want = bin_rsp_q.pop_front();
        if (got.status !== want.status || got.bucket_hit !== want.bucket_hit ||
            got.bound !== want.bound || got.count !== want.count) begin
          fails++;
          if (fails <= SHOW_LIMIT)
            $display("%0t: mismatch exp st=%0d hit=%0d bound=%h count=%h, got st=%0d hit=%0d bound=%h count=%h",
                     $realtime, want.status, want.bucket_hit, want.bound, want.count,
                     got.status, got.bucket_hit, got.bound, got.count);
        end
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if (rst || (request.valid && request.ready) || (result.valid && result.ready) ||
        (cfg.valid && cfg.ready))
      quiet_count = 0;
    else
      quiet_count++;
    if (quiet_count >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // stimulus
  initial begin
    logic [lhb_pkg::BOUND_W-1:0] ladder [$];
    logic [lhb_pkg::BOUND_W-1:0] v;
    logic [lhb_pkg::AMOUNT_W-1:0] amt;
    int round, len_l, span_ok, n, k, j, m, pick, shift;

    rst       = 1'b1;
    cfg.valid = 1'b0;
    cfg.data  = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty search range, range errors, idle command
    add_item(lhb_pkg::CMD_RECORD, 0, '0, '1);
    add_item(lhb_pkg::CMD_RECORD, 0, BOUND_MAX, 1);
    add_item(lhb_pkg::CMD_READ, lhb_pkg::BUCKETS, '0, '0);
    add_item(lhb_pkg::CMD_READ, lhb_pkg::BUCKETS + 1, '0, '0);
    add_item(lhb_pkg::CMD_READ, IDX_TOP, BOUND_MAX, '1);
    add_item(CMD_NOP, IDX_TOP, BOUND_MAX, '1);
    add_item(lhb_pkg::CMD_LOAD, lhb_pkg::BUCKETS, 5, '0);
    add_item(lhb_pkg::CMD_LOAD, IDX_TOP, BOUND_MAX, '0);
    // directed loads: index zero, duplicate, unsorted, top value
    add_item(lhb_pkg::CMD_LOAD, 0, '0, '0);
    add_item(lhb_pkg::CMD_LOAD, 1, '0, '0);
    add_item(lhb_pkg::CMD_LOAD, 1, 5, '0);
    add_item(lhb_pkg::CMD_LOAD, 2, 3, '0);
    add_item(lhb_pkg::CMD_LOAD, 2, BOUND_MAX, '0);
    add_item(lhb_pkg::CMD_LOAD, 3, BOUND_MAX, '0);
    add_item(lhb_pkg::CMD_LOAD, 0, 1, '0);
    for (k = 0; k < 3; k++) add_item(lhb_pkg::CMD_READ, k, '0, '0);
    set_bins(3);
    // records on and around each bound
    add_item(lhb_pkg::CMD_RECORD, 0, '0, 7);
    add_item(lhb_pkg::CMD_RECORD, 0, 1, '1);
    add_item(lhb_pkg::CMD_RECORD, 0, 2, 1);
    add_item(lhb_pkg::CMD_RECORD, 0, 5, '1);
    add_item(lhb_pkg::CMD_RECORD, 0, 6, 3);
    add_item(lhb_pkg::CMD_RECORD, 0, BOUND_MAX, '1);
    set_bins(2);
    add_item(lhb_pkg::CMD_RECORD, 0, BOUND_MAX, 9);
    drain();

    // random rounds: rebuild a ladder, pick a search range, then mixed traffic
    round = 0;
    while (n_items < ITEM_TARGET) begin
      stall_go = (round == 2);
      no_idle  = (round == 4);

      len_l = (round % 3 == 0) ? lhb_pkg::BUCKETS : $urandom_range(1, lhb_pkg::BUCKETS);
      shift = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(8, 44);
      ladder.delete();
      for (k = 0; k < len_l; k++)
        ladder.insert(ladder.size(), (rand48() % (BOUND_MAX - lhb_pkg::BUCKETS)) >> shift);
      ladder.sort();
      for (k = 1; k < len_l; k++)
        if (ladder[k] <= ladder[k - 1]) ladder[k] = ladder[k - 1] + 1;
      for (k = 0; k < len_l; k++) begin
        add_item(lhb_pkg::CMD_LOAD, k, ladder[k], $urandom);
        // occasional refused beat against the bound just below
        if (k > 0 && $urandom_range(0, 9) == 0) begin
          if (ladder[k - 1] == 0 || $urandom_range(0, 1) == 1) v = ladder[k - 1];
          else v = rand48() % ladder[k - 1];
          add_item(lhb_pkg::CMD_LOAD, k, v, $urandom);
        end
      end
      drain();

      // search range never reaches past the loaded prefix
      span_ok = 0;
      while (span_ok < lhb_pkg::BUCKETS && bound_loaded[span_ok]) span_ok++;
      if (span_ok == lhb_pkg::BUCKETS) begin
        case (round)
          0: n = IDX_TOP;
          3: n = lhb_pkg::BUCKETS;
          6: n = 0;
          default: begin
            case ($urandom_range(0, 3))
              0: n = $urandom_range(lhb_pkg::BUCKETS + 1, IDX_TOP);
              1: n = lhb_pkg::BUCKETS;
              default: n = $urandom_range(0, lhb_pkg::BUCKETS);
            endcase
          end
        endcase
      end else begin
        n = ($urandom_range(0, 3) == 0) ? span_ok : $urandom_range(0, span_ok);
      end
      set_bins(n);

      m = $urandom_range(40, 80);
      for (k = 0; k < m; k++) begin
        pick = $urandom_range(0, 99);
        case ($urandom_range(0, 3))
          0: amt = '0;
          1: amt = '1;
          default: amt = $urandom;
        endcase
        if (pick < 65) begin
          // durations on, just above and just below loaded bounds
          j = (span_ok > 0) ? $urandom_range(0, span_ok - 1) : 0;
          case ($urandom_range(0, 6))
            0: v = bound_mem[j];
            1: v = bound_mem[j] + 1;
            2: v = bound_mem[j] - 1;
            3: v = '0;
            4: v = BOUND_MAX;
            5: v = rand48();
            default: v = rand48() >> shift;
          endcase
          if (span_ok == 0 && $urandom_range(0, 1) == 1) v = rand48();
          add_item(lhb_pkg::CMD_RECORD, $urandom_range(0, IDX_TOP), v, amt);
        end else if (pick < 80) begin
          if (span_ok > 0 && $urandom_range(0, 9) < 7) j = $urandom_range(0, span_ok - 1);
          else j = $urandom_range(lhb_pkg::BUCKETS, IDX_TOP);
          add_item(lhb_pkg::CMD_READ, j, rand48(), amt);
        end else if (pick < 94) begin
          // stray loads, may leave the table unsorted further up
          case ($urandom_range(0, 2))
            0: j = 0;
            1: j = $urandom_range(lhb_pkg::BUCKETS, IDX_TOP);
            default: j = (span_ok == 0) ? 0 :
                         $urandom_range(1, (span_ok < lhb_pkg::BUCKETS) ?
                                           span_ok : lhb_pkg::BUCKETS - 1);
          endcase
          if (j > 0 && j < lhb_pkg::BUCKETS && $urandom_range(0, 1) == 1)
            v = bound_mem[j - 1] + lhb_pkg::BOUND_W'($urandom_range(0, 2)) - 1;
          else
            v = rand48() >> $urandom_range(0, 40);
          add_item(lhb_pkg::CMD_LOAD, j, v, amt);
        end else begin
          add_item(CMD_NOP, $urandom_range(0, IDX_TOP), rand48(), amt);
        end
      end
      drain();
      round++;
    end

    no_idle = 1'b0;
    drain();
    repeat (20) @(posedge clk);
    if (fails == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
